FILE: hdl/vsa_pkg.sv
// Package for the voice slot allocator: field widths, payload structs,
// register indexes and controller states. No dependencies.
package vsa_pkg;

	// Pool geometry
	localparam int VOICES  = 16;
	localparam int SLOT_W  = $clog2(VOICES);
	localparam int POOL_W  = $clog2(VOICES + 1);

	// Field widths fixed by the interface
	localparam int LIMIT_W = 7;
	localparam int GAIN_W  = 16;
	localparam int CLIP_W  = 16;
	localparam int TIME_W  = 32;
	localparam int IDX_W   = 6;
	localparam int PROD_W  = 2 * GAIN_W;
	localparam int FRAC_W  = 12;
	localparam int CFG_W   = 16;

	// Reset values of the configuration registers
	localparam logic [LIMIT_W-1:0]       LIMIT_RESET = LIMIT_W'(16);
	localparam logic signed [GAIN_W-1:0] MGAIN_RESET = GAIN_W'(4096);

	// Register indexes on the configuration port
	localparam logic CFG_VOICE_LIMIT = 1'b0;
	localparam logic CFG_MASTER_GAIN = 1'b1;

	// Command codes
	localparam logic CMD_PLAY   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [CLIP_W-1:0]        clip_id;
		logic signed [GAIN_W-1:0] req_gain;
		logic [TIME_W-1:0]        now_time;
		logic [IDX_W-1:0]         done_slot;
	} req_item_t;

	typedef struct packed {
		logic                     accepted;
		logic [IDX_W-1:0]         voice_slot;
		logic                     stolen;
		logic [CLIP_W-1:0]        play_clip;
		logic signed [GAIN_W-1:0] play_gain;
	} rsp_item_t;

	// Gain unit status toward the controller
	typedef struct packed {
		logic                     nonpos;
		logic signed [GAIN_W-1:0] gain;
	} gain_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DECIDE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_WRITE,
		ST_OUT
	} vsa_state_t;

endpackage

FILE: hdl/vsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module vsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and a read port with registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/vsa_gain.sv
// Gain unit: registered Q4.12 multiply, then round half up and saturate.
// Depends on vsa_pkg.
module vsa_gain import vsa_pkg::*; (
	input  logic                     clk,
	input  logic signed [GAIN_W-1:0] req_gain,
	input  logic signed [GAIN_W-1:0] master_gain,
	output gain_res_t                res
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;
	logic                     sat;

	// Register the exact Q8.24 product
	always_ff @(posedge clk) begin
		prod_s1 <= req_gain * master_gain;
	end

	// Round half up; the value is only used when the product is positive
	always_comb begin
		rnd = prod_s1 + PROD_W'(1 << (FRAC_W - 1));
		sat = |rnd[PROD_W-2:FRAC_W+GAIN_W-1];
		res.nonpos = prod_s1[PROD_W-1] || (prod_s1 == '0);
		res.gain = sat ? GAIN_W'(16'sh7FFF) : rnd[FRAC_W+GAIN_W-1:FRAC_W];
	end

endmodule

FILE: hdl/vsa_alloc.sv
// Allocation controller: playing flags, pool size, start stamp RAM,
// oldest-stamp scan and the result register. Depends on vsa_pkg, vsa_ram.
module vsa_alloc import vsa_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  req_item_t                 req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output rsp_item_t                 rsp,
	input  logic [LIMIT_W-1:0]        voice_limit,
	output logic signed [GAIN_W-1:0]  cur_gain,
	input  gain_res_t                 gain_res
);

	vsa_state_t          state_q, state_nx;
	req_item_t           item_q;
	rsp_item_t           res_q;
	logic [VOICES-1:0]   playing_q;
	logic [POOL_W-1:0]   pool_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                stolen_q;
	logic [SLOT_W-1:0]   scan_q;
	logic                cmp_vld_q;
	logic [SLOT_W-1:0]   cmp_idx_q;
	logic [TIME_W-1:0]   oldest_q;
	logic [TIME_W-1:0]   stamp_rd;

	logic                reject;
	logic                idle_hit;
	logic [SLOT_W-1:0]   idle_idx;
	logic [LIMIT_W-1:0]  cap;
	logic                can_grow;
	logic                scan_last;
	logic                fin_hit;
	logic                out_free;
	logic                ram_we;

	assign cur_gain = item_q.req_gain;

	// Stamp store; writes and scan reads never fall in the same cycle
	vsa_ram #(.WIDTH(TIME_W), .DEPTH(VOICES)) u_stamp (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (item_q.now_time),
		.raddr (scan_q),
		.rdata (stamp_rd)
	);

	// Find the lowest idle slot inside the pool
	always_comb begin
		idle_hit = 1'b0;
		idle_idx = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (POOL_W'(i) < pool_q && !playing_q[i]) begin
				idle_hit = 1'b1;
				idle_idx = SLOT_W'(i);
			end
		end
	end

	// Pool growth, rejection and scan end
	always_comb begin
		cap       = (voice_limit < LIMIT_W'(VOICES)) ? voice_limit : LIMIT_W'(VOICES);
		can_grow  = LIMIT_W'(pool_q) < cap;
		reject    = gain_res.nonpos || (item_q.clip_id == '0);
		scan_last = (POOL_W'(scan_q) == POOL_W'(pool_q - POOL_W'(1)));
		fin_hit   = item_q.done_slot < IDX_W'(pool_q);
		out_free  = !rsp_valid || rsp_ready;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:      if (req_valid) state_nx = ST_MUL;
			ST_MUL:       state_nx = ST_DECIDE;
			ST_DECIDE: begin
				if (item_q.cmd == CMD_FINISH) begin
					state_nx = ST_IDLE;
				end else if (reject) begin
					state_nx = ST_OUT;
				end else if (idle_hit || can_grow) begin
					state_nx = ST_WRITE;
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN:      if (scan_last) state_nx = ST_SCAN_LAST;
			ST_SCAN_LAST: state_nx = ST_WRITE;
			ST_WRITE:     state_nx = ST_OUT;
			ST_OUT:       if (out_free) state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	// Handshake and RAM strobes
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		ram_we    = (state_q == ST_WRITE);
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			playing_q <= '0;
			pool_q    <= '0;
			cmp_vld_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q   <= state_nx;
			cmp_vld_q <= (state_q == ST_SCAN);
			// A finish event inside the pool clears its flag; a grown pool counts up; a new voice sets its flag
			if (state_q == ST_DECIDE && item_q.cmd == CMD_FINISH && fin_hit) begin
				playing_q[item_q.done_slot[SLOT_W-1:0]] <= 1'b0;
			end
			if (state_q == ST_DECIDE && item_q.cmd == CMD_PLAY && !reject
					&& !idle_hit && can_grow) begin
				pool_q <= pool_q + POOL_W'(1);
			end
			if (state_q == ST_WRITE) begin
				playing_q[slot_q] <= 1'b1;
			end
			// Hold the result until the transfer
			if (state_q == ST_OUT && out_free) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Payload and scan registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		cmp_idx_q <= scan_q;
		case (state_q)
			ST_DECIDE: begin
				scan_q   <= '0;
				oldest_q <= item_q.now_time;
				stolen_q <= 1'b0;
				res_q    <= '0;
				if (idle_hit) begin
					slot_q <= idle_idx;
				end else if (can_grow) begin
					slot_q <= SLOT_W'(pool_q);
				end else begin
					slot_q   <= '0;
					stolen_q <= 1'b1;
				end
			end
			ST_SCAN: begin
				scan_q <= scan_q + SLOT_W'(1);
			end
			ST_WRITE: begin
				res_q.accepted   <= 1'b1;
				res_q.voice_slot <= IDX_W'(slot_q);
				res_q.stolen     <= stolen_q;
				res_q.play_clip  <= item_q.clip_id;
				res_q.play_gain  <= gain_res.gain;
			end
			default: ;
		endcase
		// Keep the strictly oldest stamp, lowest index on ties
		if (cmp_vld_q && stamp_rd < oldest_q) begin
			oldest_q <= stamp_rd;
			slot_q   <= cmp_idx_q;
		end
		if (state_q == ST_OUT && out_free) begin
			rsp <= res_q;
		end
	end

endmodule

FILE: hdl/voice_slot_allocator_core.sv
// Voice slot allocator top level: configuration registers, gain unit and
// allocation controller. Depends on vsa_pkg, vsa_gain, vsa_alloc.
//
// Usage: items enter on req (valid/ready). A play request yields one result
// on rsp (valid/ready); a finish event yields none. Register writes arrive on
// cfg (index 0 voice_limit, index 1 master_gain, always ready) and are to be
// made only while the block is idle; the block itself does not enforce this.
// Sequence: after the request transfer the controller steps through
// ST_MUL, ST_DECIDE, ST_WRITE and ST_OUT when an idle slot is found or the
// pool grows; a rejected request skips ST_WRITE. Stealing adds an
// oldest-stamp scan through the stamp RAM read port, one slot per cycle,
// over the pool in ST_SCAN, closed by ST_SCAN_LAST, before ST_WRITE. Only
// one item is in flight; a finish event returns to idle from ST_DECIDE.
// Reset clears the playing flags, the pool size and rsp_valid, returns to idle
// and loads voice_limit 16 and master_gain 1.0; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// request is still taken, and its result waits until that register frees.
module voice_slot_allocator_core import vsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_item_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_item_t         rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [LIMIT_W-1:0]       voice_limit_q;
	logic signed [GAIN_W-1:0] master_gain_q;
	logic signed [GAIN_W-1:0] cur_gain;
	gain_res_t                gain_res;

	assign cfg_ready = 1'b1;

	// Configuration writes; a zero voice limit is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_limit_q <= LIMIT_RESET;
			master_gain_q <= MGAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VOICE_LIMIT: begin
					if (cfg_data[LIMIT_W-1:0] != '0) begin
						voice_limit_q <= cfg_data[LIMIT_W-1:0];
					end
				end
				CFG_MASTER_GAIN: master_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	vsa_gain u_gain (
		.clk         (clk),
		.req_gain    (cur_gain),
		.master_gain (master_gain_q),
		.res         (gain_res)
	);

	vsa_alloc u_alloc (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.voice_limit (voice_limit_q),
		.cur_gain    (cur_gain),
		.gain_res    (gain_res)
	);

endmodule
